// ----- rtl/bank_mapper_with_cycle_irq_counter_assert.svh -----
// Assertion macros for the bank mapper
`ifndef BANK_MAPPER_WITH_CYCLE_IRQ_COUNTER_ASSERT_SVH
`define BANK_MAPPER_WITH_CYCLE_IRQ_COUNTER_ASSERT_SVH

// check a condition in the same cycle
`define BMAP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bank mapper assertion failed");

// check a condition in the next cycle
`define BMAP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bank mapper assertion failed");

`endif

// ----- rtl/bmap_pkg.sv -----
// Types and constants for the bank mapper
`default_nettype none

package bmap_pkg;

  typedef enum logic [4:0] {
    SEL_CHR0   = 5'h11,
    SEL_CHR1   = 5'h13,
    SEL_CHR2   = 5'h15,
    SEL_CHR3   = 5'h17,
    SEL_CNT_LO = 5'h18,
    SEL_CNT_HI = 5'h19,
    SEL_CTRL   = 5'h1B,
    SEL_MIRROR = 5'h1D,
    SEL_PRG    = 5'h1F
  } reg_sel_e;

  localparam logic CFG_CHR_MAX = 1'b0;
  localparam logic CFG_PRG_MAX = 1'b1;

  localparam logic [7:0]  BANK_MAX_RST = 8'hFF;
  localparam logic [15:0] CNT_RELOAD   = 16'hFFFF;
  localparam int unsigned CTRL_EN_BIT  = 4;

  function automatic logic [7:0] clamp_bank(input logic [7:0] v, input logic [7:0] max);
    return (v > max) ? (v & max) : v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/bank_mapper_with_cycle_irq_counter.sv -----
// Bank mapper with CPU-cycle IRQ down-counter
// Flow: an input register feeds the state registers; a request waits there while a
//   result is held unread, and otherwise updates the state registers and result.
// Throughput: one request per cycle while out_ready_i is high, as the state registers
//   double as the result register, so requests stream back to back.
// Reset: all bank, mirror and counter state clears to zero, no result pending,
//   and both bank maxima return to 255.
`default_nettype none

`include "bank_mapper_with_cycle_irq_counter_assert.svh"

module bank_mapper_with_cycle_irq_counter
  import bmap_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        cmd_i,
  input  wire logic [15:0] bus_address_i,
  input  wire logic [7:0]  write_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             irq_line_o,
  output logic [7:0]       chr_bank_0_o,
  output logic [7:0]       chr_bank_1_o,
  output logic [7:0]       chr_bank_2_o,
  output logic [7:0]       chr_bank_3_o,
  output logic [7:0]       prg_bank_o,
  output logic [1:0]       mirror_mode_o
);

  logic        req_valid_q;
  logic        cmd_q;
  logic [15:0] addr_q;
  logic [7:0]  data_q;
  logic        out_valid_q;
  logic        advance;

  logic [7:0]  chr_max_q, prg_max_q;
  logic [7:0]  chr_q [4];
  logic [7:0]  chr_d [4];
  logic [7:0]  prg_q, prg_d;
  logic [1:0]  mirror_q, mirror_d;
  logic [15:0] cnt_q, cnt_d;
  logic        flip_q, flip_d;
  logic        en_q, en_d;
  logic        delay_q, delay_d;
  logic        pending_q, pending_d;
  logic [15:0] cnt_dec;

  assign advance    = req_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || advance;
  assign cnt_dec    = cnt_q - 16'd1;

  always_comb begin
    chr_d     = chr_q;
    prg_d     = prg_q;
    mirror_d  = mirror_q;
    cnt_d     = cnt_q;
    flip_d    = flip_q;
    en_d      = en_q;
    delay_d   = delay_q;
    pending_d = pending_q;
    if (cmd_q) begin
      if (delay_q) begin
        delay_d   = 1'b0;
        pending_d = 1'b1;
      end
      if (en_q && (cnt_q != 16'd0)) begin
        if (cnt_dec == 16'd0) begin
          en_d    = 1'b0;
          cnt_d   = CNT_RELOAD;
          delay_d = 1'b1;
        end else begin
          cnt_d = cnt_dec;
        end
      end
    end else begin
      case (addr_q[15:11])
        SEL_CHR0: chr_d[0] = clamp_bank(data_q, chr_max_q);
        SEL_CHR1: chr_d[1] = clamp_bank(data_q, chr_max_q);
        SEL_CHR2: chr_d[2] = clamp_bank(data_q, chr_max_q);
        SEL_CHR3: chr_d[3] = clamp_bank(data_q, chr_max_q);
        SEL_CNT_LO, SEL_CNT_HI: begin
          flip_d = !flip_q;
          if (!flip_q) begin
            cnt_d = {data_q, cnt_q[7:0]};
          end else begin
            cnt_d = {cnt_q[15:8], data_q};
          end
        end
        SEL_CTRL: begin
          flip_d    = 1'b0;
          en_d      = data_q[CTRL_EN_BIT];
          pending_d = 1'b0;
        end
        SEL_MIRROR: mirror_d = data_q[1:0];
        SEL_PRG:    prg_d    = clamp_bank(data_q, prg_max_q);
        default: ;
      endcase
    end
  end

  // hold the request until the state stage takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q  <= cmd_i;
      addr_q <= bus_address_i;
      data_q <= write_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chr_max_q <= BANK_MAX_RST;
      prg_max_q <= BANK_MAX_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_CHR_MAX) begin
        chr_max_q <= cfg_data_i;
      end else begin
        prg_max_q <= cfg_data_i;
      end
    end
  end

  // advance state; the state registers double as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      chr_q       <= '{default: 8'd0};
      prg_q       <= 8'd0;
      mirror_q    <= 2'd0;
      cnt_q       <= 16'd0;
      flip_q      <= 1'b0;
      en_q        <= 1'b0;
      delay_q     <= 1'b0;
      pending_q   <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        chr_q       <= chr_d;
        prg_q       <= prg_d;
        mirror_q    <= mirror_d;
        cnt_q       <= cnt_d;
        flip_q      <= flip_d;
        en_q        <= en_d;
        delay_q     <= delay_d;
        pending_q   <= pending_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign irq_line_o    = pending_q;
  assign chr_bank_0_o  = chr_q[0];
  assign chr_bank_1_o  = chr_q[1];
  assign chr_bank_2_o  = chr_q[2];
  assign chr_bank_3_o  = chr_q[3];
  assign prg_bank_o    = prg_q;
  assign mirror_mode_o = mirror_q;

  `BMAP_ASSERT_NEXT(a_cnt_expire, advance && cmd_q && en_q && (cnt_q == 16'd1), delay_q && !en_q && (cnt_q == CNT_RELOAD))
  `BMAP_ASSERT_NEXT(a_delay_raise, advance && cmd_q && delay_q, pending_q)
  `BMAP_ASSERT_NOW(a_ack_only, $fell(pending_q), $past(advance && !cmd_q && (addr_q[15:11] == SEL_CTRL)))
  `BMAP_ASSERT_NEXT(a_hold_state, !advance, $stable(cnt_q) && $stable(pending_q))

endmodule

`default_nettype wire
